// ===== hw/rtl/lobm_pkg.sv =====
// Package for the limit order book matcher: sizes, result codes, command codes, state enum, structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lobm_pkg;
    localparam int ORDER_SLOTS = 32;
    localparam int SLOT_W = $clog2(ORDER_SLOTS);
    localparam int CHAIN_SEG = 8;
    localparam int CHAIN_LAT = (ORDER_SLOTS - 1) / CHAIN_SEG;
    localparam int SETTLE_W = $clog2(CHAIN_LAT + 2);

    localparam logic [1:0] FUNC_ADD    = 2'd0;
    localparam logic [1:0] FUNC_CANCEL = 2'd1;
    localparam logic [1:0] FUNC_MATCH  = 2'd2;

    localparam logic [2:0] KIND_ADDED     = 3'd0;
    localparam logic [2:0] KIND_FULL      = 3'd1;
    localparam logic [2:0] KIND_CANCELLED = 3'd2;
    localparam logic [2:0] KIND_NOT_FOUND = 3'd3;
    localparam logic [2:0] KIND_TRADE     = 3'd4;
    localparam logic [2:0] KIND_NO_TRADE  = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CANCEL_SELL, ST_SCAN, ST_TRADE, ST_CHECK, ST_OUT
    } t_state;

    // Best-order candidate travelling along the chain.
    typedef struct packed {
        logic        valid;
        logic [31:0] price;
        logic [31:0] elapsed;
        logic [SLOT_W-1:0] slot;
    } t_cand;

    // Slot command broadcast from the controller to every cell.
    typedef struct packed {
        logic        add;
        logic        cancel;
        logic        cancel_side;
        logic        trade;
        logic [SLOT_W-1:0] bid_slot;
        logic [SLOT_W-1:0] ask_slot;
        logic [31:0] trade_qty;
    } t_cmd;
endpackage
`default_nettype wire

// ===== hw/rtl/lobm_if.sv =====
// Valid/ready channel interface with payload of type T.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
interface lobm_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/lobm_cell.sv =====
// One order slot of the book: holds the order and merges best candidates from its neighbor.
// Depends on lobm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lobm_cell import lobm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [SLOT_W-1:0] i_index,
    input  wire logic        i_is_free_first,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_cancel_price,
    input  wire logic        i_side,
    input  wire logic [31:0] i_price,
    input  wire logic [31:0] i_qty,
    input  wire logic [63:0] i_time,
    input  wire logic [31:0] i_ident,
    input  wire logic [31:0] i_arrival,
    input  wire t_cand       i_bid,
    input  wire t_cand       i_ask,
    input  wire t_cand       i_cxl,
    input  wire logic        i_cxl_side,
    input  wire logic [31:0] i_cxl_id,
    output t_cand            o_bid,
    output t_cand            o_ask,
    output t_cand            o_cxl,
    output logic             o_used,
    output logic [31:0]      o_qty,
    output logic [63:0]      o_time,
    output logic [31:0]      o_ident
);
    logic        r_used;
    logic        r_side;
    logic [31:0] r_price, r_qty, r_ident, r_age;
    logic [63:0] r_time;
    logic [31:0] w_el, w_left;
    logic        w_hit;

    assign w_el = i_arrival - r_age;
    assign w_hit = r_used && r_side == i_cxl_side && r_ident == i_cxl_id;

    always_comb begin
        o_bid = i_bid;
        if (r_used && !r_side && (!i_bid.valid || r_price > i_bid.price ||
            (r_price == i_bid.price && w_el > i_bid.elapsed))) begin
            o_bid = '{1'b1, r_price, w_el, i_index};
        end
        o_ask = i_ask;
        if (r_used && r_side && (!i_ask.valid || r_price < i_ask.price ||
            (r_price == i_ask.price && w_el > i_ask.elapsed))) begin
            o_ask = '{1'b1, r_price, w_el, i_index};
        end
        o_cxl = i_cxl;
        if (w_hit && (!i_cxl.valid || r_price < i_cxl.price)) begin
            o_cxl = '{1'b1, r_price, 32'd0, i_index};
        end
    end

    assign w_left = r_qty - i_cmd.trade_qty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= 1'b0;
        end else if (i_cmd.add && i_is_free_first) begin
            r_used <= 1'b1;
        end else if (i_cmd.cancel && r_used && r_side == i_cmd.cancel_side &&
                     r_ident == i_cxl_id && r_price == i_cancel_price) begin
            r_used <= 1'b0;
        end else if (i_cmd.trade && (i_index == i_cmd.bid_slot ||
                     i_index == i_cmd.ask_slot) && w_left == 32'd0) begin
            r_used <= 1'b0;
        end
        if (i_cmd.add && i_is_free_first) begin
            r_side  <= i_side;
            r_price <= i_price;
            r_qty   <= i_qty;
            r_time  <= i_time;
            r_ident <= i_ident;
            r_age   <= i_arrival;
        end else if (i_cmd.trade && (i_index == i_cmd.bid_slot ||
                     i_index == i_cmd.ask_slot)) begin
            r_qty <= w_left;
        end
    end

    assign o_used  = r_used;
    assign o_qty   = r_qty;
    assign o_time  = r_time;
    assign o_ident = r_ident;
endmodule
`default_nettype wire

// ===== hw/rtl/lobm_chain.sv =====
// Row of order cells with registered candidate hand-off every eight cells.
// Depends on lobm_pkg and lobm_cell.
`timescale 1ns / 1ps
`default_nettype none
module lobm_chain import lobm_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire t_cmd        i_cmd,
    input  wire logic [31:0] i_cancel_price,
    input  wire logic        i_side,
    input  wire logic [31:0] i_price,
    input  wire logic [31:0] i_qty,
    input  wire logic [63:0] i_time,
    input  wire logic [31:0] i_ident,
    input  wire logic [31:0] i_arrival,
    input  wire logic        i_cxl_side,
    output t_cand            o_bid,
    output t_cand            o_ask,
    output t_cand            o_cxl,
    output logic             o_full,
    output logic [31:0]      o_bid_qty,
    output logic [31:0]      o_ask_qty,
    output logic [63:0]      o_bid_time,
    output logic [63:0]      o_ask_time,
    output logic [31:0]      o_bid_ident,
    output logic [31:0]      o_ask_ident
);
    t_cand w_bid [ORDER_SLOTS+1];
    t_cand w_ask [ORDER_SLOTS+1];
    t_cand w_cxl [ORDER_SLOTS+1];
    t_cand w_obid [ORDER_SLOTS];
    t_cand w_oask [ORDER_SLOTS];
    t_cand w_ocxl [ORDER_SLOTS];
    logic [ORDER_SLOTS-1:0] w_used;
    logic [ORDER_SLOTS:0]   w_free_seen;
    logic [31:0] w_qty [ORDER_SLOTS];
    logic [63:0] w_time [ORDER_SLOTS];
    logic [31:0] w_ident [ORDER_SLOTS];

    assign w_bid[0] = '0;
    assign w_ask[0] = '0;
    assign w_cxl[0] = '0;
    assign w_free_seen[0] = 1'b0;

    for (genvar g = 0; g < ORDER_SLOTS; g++) begin : g_cell
        assign w_free_seen[g+1] = w_free_seen[g] | ~w_used[g];
        lobm_cell u_cell (
            .i_clk, .i_rst_n,
            .i_index(SLOT_W'(g)),
            .i_is_free_first(~w_used[g] & ~w_free_seen[g]),
            .i_cmd, .i_cancel_price, .i_side, .i_price, .i_qty, .i_time,
            .i_ident, .i_arrival,
            .i_bid(w_bid[g]), .i_ask(w_ask[g]), .i_cxl(w_cxl[g]),
            .i_cxl_side, .i_cxl_id(i_ident),
            .o_bid(w_obid[g]), .o_ask(w_oask[g]), .o_cxl(w_ocxl[g]),
            .o_used(w_used[g]), .o_qty(w_qty[g]), .o_time(w_time[g]),
            .o_ident(w_ident[g])
        );
        if ((g % CHAIN_SEG) == CHAIN_SEG - 1 && g != ORDER_SLOTS - 1) begin : g_stage
            t_cand r_bid, r_ask, r_cxl;
            always_ff @(posedge i_clk) begin
                r_bid <= w_obid[g];
                r_ask <= w_oask[g];
                r_cxl <= w_ocxl[g];
            end
            assign w_bid[g+1] = r_bid;
            assign w_ask[g+1] = r_ask;
            assign w_cxl[g+1] = r_cxl;
        end else begin : g_pass
            assign w_bid[g+1] = w_obid[g];
            assign w_ask[g+1] = w_oask[g];
            assign w_cxl[g+1] = w_ocxl[g];
        end
    end

    assign o_bid  = w_bid[ORDER_SLOTS];
    assign o_ask  = w_ask[ORDER_SLOTS];
    assign o_cxl  = w_cxl[ORDER_SLOTS];
    assign o_full = &w_used;
    assign o_bid_qty   = w_qty[o_bid.slot];
    assign o_ask_qty   = w_qty[o_ask.slot];
    assign o_bid_time  = w_time[o_bid.slot];
    assign o_ask_time  = w_time[o_ask.slot];
    assign o_bid_ident = w_ident[o_bid.slot];
    assign o_ask_ident = w_ident[o_ask.slot];
endmodule
`default_nettype wire

// ===== hw/rtl/limit_order_book_matcher.sv =====
// Top level of the limit order book matcher: command decode, trade sequencing, result register.
// Depends on lobm_pkg, lobm_if and lobm_chain.
`timescale 1ns / 1ps
`default_nettype none
// A book of 32 order slots, each a cell in a chain that offers the best bid, best ask and
// cancel candidates along the row, with a register after every eight cells, so a change in
// the book reaches the end of the chain through those registers. An add shows its result
// beat once the chain has settled; a cancel looks for the id on the buy side first and then
// on the sell side. A match shows each trade in its own result beat, and each further trade
// follows once the previous beat is taken: select the pair, apply it, let the chain settle
// and decide whether another trade follows. The next command is taken the cycle after the
// last result beat is delivered.
module limit_order_book_matcher import lobm_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    lobm_if.sink     cmd,
    lobm_if.source   res
);
    typedef struct packed {
        logic [1:0]  func;
        logic        side;
        logic [31:0] price;
        logic [31:0] quantity;
        logic [63:0] timestamp;
        logic [31:0] order_id;
    } t_in;

    t_state r_state, n_state;
    t_in    r_in;
    t_in    w_in;
    logic [31:0] r_arrival;
    logic [SLOT_W-1:0] r_count;
    logic   r_cxl_side;
    logic   r_pend;
    logic [SETTLE_W-1:0] r_settle;
    logic   w_stable, w_side_flip, w_change;
    logic [2:0] r_kind, n_kind;
    logic   r_last, n_last;
    logic [63:0] r_tt;
    logic [31:0] r_bid_id, r_ask_id, r_tp, r_tq;
    t_cmd   w_cmd;
    t_cand  w_bid, w_ask, w_cxl;
    logic   w_full, w_cross;
    logic [31:0] w_bq, w_aq, w_bi, w_ai, w_q;
    logic [63:0] w_bt, w_at;

    lobm_chain u_chain (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_cancel_price(w_cxl.price),
        .i_side(r_in.side), .i_price(r_in.price), .i_qty(r_in.quantity),
        .i_time(r_in.timestamp), .i_ident(r_in.order_id), .i_arrival(r_arrival),
        .i_cxl_side(r_cxl_side),
        .o_bid(w_bid), .o_ask(w_ask), .o_cxl(w_cxl), .o_full(w_full),
        .o_bid_qty(w_bq), .o_ask_qty(w_aq), .o_bid_time(w_bt), .o_ask_time(w_at),
        .o_bid_ident(w_bi), .o_ask_ident(w_ai)
    );

    assign w_in = cmd.data;
    assign w_cross = w_bid.valid && w_ask.valid && w_bid.price >= w_ask.price;
    assign w_q = (w_bq < w_aq) ? w_bq : w_aq;
    assign w_stable = r_settle == '0;
    assign w_side_flip = r_state == ST_CANCEL_SELL && w_stable && !w_cxl.valid && !r_cxl_side;
    assign w_change = (cmd.valid && cmd.ready && w_in.func == FUNC_CANCEL) || w_cmd.add ||
                      w_cmd.cancel || w_cmd.trade || w_side_flip;

    always_comb begin
        n_state = r_state;
        n_kind = r_kind;
        n_last = r_last;
        w_cmd = '0;
        w_cmd.cancel_side = r_cxl_side;
        w_cmd.bid_slot = w_bid.slot;
        w_cmd.ask_slot = w_ask.slot;
        w_cmd.trade_qty = w_q;
        unique case (r_state)
            ST_IDLE: begin
                if (r_pend) begin
                    unique case (r_in.func)
                        FUNC_ADD: begin
                            w_cmd.add = !w_full;
                            n_kind = w_full ? KIND_FULL : KIND_ADDED;
                            n_last = 1'b1;
                            n_state = ST_OUT;
                        end
                        FUNC_CANCEL: begin
                            n_state = ST_CANCEL_SELL;
                        end
                        FUNC_MATCH: begin
                            n_state = ST_SCAN;
                        end
                        default: begin
                            n_kind = KIND_NO_TRADE;
                            n_last = 1'b1;
                            n_state = ST_OUT;
                        end
                    endcase
                end
            end
            ST_CANCEL_SELL: begin
                if (w_stable) begin
                    w_cmd.cancel = w_cxl.valid;
                    if (w_cxl.valid || r_cxl_side) begin
                        n_kind = w_cxl.valid ? KIND_CANCELLED : KIND_NOT_FOUND;
                        n_last = 1'b1;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_SCAN: begin
                if (w_stable) begin
                    if (w_cross) begin
                        n_kind = KIND_TRADE;
                        n_last = 1'b0;
                        n_state = ST_TRADE;
                    end else begin
                        n_kind = KIND_NO_TRADE;
                        n_last = 1'b1;
                        n_state = ST_OUT;
                    end
                end
            end
            ST_TRADE: begin
                w_cmd.trade = 1'b1;
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (w_stable) begin
                    n_last = !w_cross || (r_count == SLOT_W'(ORDER_SLOTS - 1));
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (res.ready && w_stable) begin
                    n_state = (r_in.func == FUNC_MATCH && !r_last) ? ST_SCAN : ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_pend    <= 1'b0;
            r_arrival <= '0;
            r_count   <= '0;
            r_cxl_side <= 1'b0;
            r_settle  <= SETTLE_W'(CHAIN_LAT);
            r_last    <= 1'b0;
            r_kind    <= KIND_NO_TRADE;
        end else begin
            r_state <= n_state;
            r_kind  <= n_kind;
            r_last  <= n_last;
            if (w_change) begin
                r_settle <= SETTLE_W'(CHAIN_LAT);
            end else if (!w_stable) begin
                r_settle <= r_settle - SETTLE_W'(1);
            end
            if (cmd.valid && cmd.ready) begin
                r_pend <= 1'b1;
                r_count <= '0;
                r_cxl_side <= 1'b0;
            end else if (r_state == ST_IDLE) begin
                r_pend <= 1'b0;
            end
            if (w_cmd.add) begin
                r_arrival <= r_arrival + 32'd1;
            end
            if (w_side_flip) begin
                r_cxl_side <= 1'b1;
            end
            if (r_state == ST_TRADE) begin
                r_count <= r_count + SLOT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.valid && cmd.ready) begin
            r_in <= cmd.data;
        end
        if (r_state == ST_SCAN && w_stable && w_cross) begin
            r_tt <= (w_bt > w_at) ? w_bt : w_at;
            r_bid_id <= w_bi;
            r_ask_id <= w_ai;
            r_tp <= w_ask.price;
            r_tq <= w_q;
        end else if (r_state == ST_IDLE || r_state == ST_CANCEL_SELL) begin
            r_tt <= '0;
            r_bid_id <= '0;
            r_ask_id <= '0;
            r_tp <= '0;
            r_tq <= '0;
        end
    end

    assign cmd.ready = r_state == ST_IDLE && !r_pend;
    assign res.valid = r_state == ST_OUT && w_stable;
    assign res.data = {r_kind, r_tt, r_bid_id, r_ask_id, r_tp, r_tq, r_last,
                       w_bid.valid, w_bid.valid ? w_bid.price : 32'd0,
                       w_ask.valid, w_ask.valid ? w_ask.price : 32'd0};

    a_out_only_in_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res.valid |-> !cmd.ready) else $error("result shown while accepting");
    a_trade_qty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_TRADE) |-> (r_kind == KIND_TRADE)) else $error("trade kind");
    a_accept_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.valid && cmd.ready) |=> r_pend) else $error("pending lost");
endmodule
`default_nettype wire
